// File: rtl/flw_pkg.sv
// ----------------------------------------------------------------------------
// flw_pkg: shared types and constants of the TCP flow rewrite engine
// Commands, pool events, sequencer states, table keys and payload layouts.
// ----------------------------------------------------------------------------
package flw_pkg;

  // Default number of entries in each flow table.
  localparam int FLW_TABLE_ENTRIES = 16;

  // Index of the last checksum update step.
  localparam logic [2:0] CSUM_LAST = 3'd4;

  typedef enum logic [1:0] {
    CMD_INBOUND    = 2'd0,
    CMD_OUTBOUND   = 2'd1,
    CMD_LOAD_PROP  = 2'd2,
    CMD_LOAD_RANGE = 2'd3
  } flw_cmd_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_CLEAR  = 2'd1,
    EV_ADD    = 2'd2,
    EV_REMOVE = 2'd3
  } flw_event_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_READ,
    ST_ACT,
    ST_APPLY,
    ST_CSUM,
    ST_RANGE,
    ST_CLASS,
    ST_DONE
  } flw_state_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
  } flw_key_t;

  // Target address and port with seq/ack numbers or offsets.
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] a;
    logic [31:0] b;
  } flw_target_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] stop;
  } flw_range_t;

  typedef struct packed {
    flw_cmd_t    command;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic        fin_flag;
    logic        rst_flag;
    logic [15:0] ip_checksum;
    logic [15:0] tcp_checksum;
    logic [15:0] range_stop;
  } flw_item_t;

  typedef struct packed {
    logic [31:0] out_src_addr;
    logic [15:0] out_src_port;
    logic [31:0] out_dst_addr;
    logic [15:0] out_dst_port;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] out_ip_checksum;
    logic [15:0] out_tcp_checksum;
    logic        rewritten;
    flw_event_t  pool_event;
    logic        table_full;
  } flw_result_t;

endpackage

// File: rtl/flw_if.sv
// ----------------------------------------------------------------------------
// flw_if: valid/ready channels of the TCP flow rewrite engine
// One channel carries header items in, the other carries results out.
// ----------------------------------------------------------------------------
interface flw_item_if import flw_pkg::*; ();
  logic      valid;
  logic      ready;
  flw_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface flw_result_if import flw_pkg::*; ();
  logic        valid;
  logic        ready;
  flw_result_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// File: rtl/flw_csum.sv
// ----------------------------------------------------------------------------
// flw_csum: shared incremental checksum unit
// Replaces one 32-bit item in a 16-bit ones' complement checksum.
// ----------------------------------------------------------------------------
module flw_csum import flw_pkg::*; (
  input  logic [15:0] hc,
  input  logic [31:0] old_val,
  input  logic [31:0] new_val,
  output logic [15:0] result
);

  logic [18:0] sum;
  logic [16:0] fold1;
  logic [16:0] fold2;

  // HC' = ~(~HC + ~m + m'), carries folded back twice.
  always_comb begin
    sum = {3'b000, ~hc} + {3'b000, ~old_val[31:16]} + {3'b000, ~old_val[15:0]}
        + {3'b000, new_val[31:16]} + {3'b000, new_val[15:0]};
    fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
    fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
    result = ~fold2[15:0];
  end

endmodule

// File: rtl/flw_table.sv
// ----------------------------------------------------------------------------
// flw_table: keyed flow table
// Valid bits and keys in flops with a parallel compare, payload in a memory
// with a registered read at the matching slot.
// ----------------------------------------------------------------------------
module flw_table import flw_pkg::*; #(
  parameter int ENTRIES = FLW_TABLE_ENTRIES,
  parameter int DATA_W  = 32,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  flw_key_t          lookup,
  output logic              hit,
  output logic [IDX_W-1:0]  hit_idx,
  output logic              has_free,
  output logic [IDX_W-1:0]  free_idx,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  flw_key_t          wr_key,
  input  logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0] rd_data
);

  logic              valid [ENTRIES];
  flw_key_t          keys  [ENTRIES];
  logic [DATA_W-1:0] mem   [ENTRIES];

  // Lowest matching slot and lowest free slot.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && keys[i] == lookup) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Valid bits are cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) valid[i] <= 1'b0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_idx] <= wr_key;
    end
  end

  // Payload memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[hit_idx];
  end

endmodule

// File: rtl/tcp_flow_rewrite_engine.sv
// ----------------------------------------------------------------------------
// tcp_flow_rewrite_engine: TCP source NAT with sequence and ack offsets
// Sequencer around four flow tables and one shared checksum unit.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the hdr channel: inbound or outbound headers, proposal loads
// and port range loads. Every item gives exactly one result transaction on
// the res channel, in order.
// The five checksum updates run one per cycle through the single shared
// ones' complement unit, and each table payload comes from a memory with a
// registered read.
// hdr.ready is high only while the sequencer is idle, so one item is in
// work at a time; the next item is taken in the cycle after the result loads.
// The result sits in an output register. A stalled receiver holds it there
// while the next item is already taken; that item waits at its end until the
// register is free.
// Reset clears all table valid bits at once and empties the output register;
// hdr.ready stays low during reset and the block is ready in the cycle after.
// ----------------------------------------------------------------------------
module tcp_flow_rewrite_engine import flw_pkg::*; #(
  parameter int TABLE_ENTRIES = FLW_TABLE_ENTRIES
) (
  input logic          clk,
  input logic          rst,
  flw_item_if.sink     hdr,
  flw_result_if.source res
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int TGT_W = $bits(flw_target_t);
  localparam int RNG_W = $bits(flw_range_t);

  flw_state_t state;
  flw_state_t state_next;

  // Item registers.
  flw_cmd_t    cmd;
  logic [31:0] sa;
  logic [15:0] sp;
  logic [31:0] da;
  logic [15:0] dp;
  logic [31:0] seq;
  logic [31:0] ack;
  logic        fin;
  logic        rstf;
  logic [15:0] ipc;
  logic [15:0] tcc;
  logic [15:0] stop;

  flw_target_t tgt;
  logic [31:0] nseq;
  logic [31:0] nack;
  logic [2:0]  step;
  logic        rew;
  logic        full;
  flw_event_t  ev;

  logic        res_valid;
  flw_result_t res_item;
  flw_result_t res_item_next;
  logic        out_free;

  // Table ports.
  flw_key_t          prop_lk, inb_lk, outb_lk, rng_lk;
  logic              prop_hit, inb_hit, outb_hit, rng_hit;
  logic [IDX_W-1:0]  prop_hidx, inb_hidx, outb_hidx, rng_hidx;
  logic              prop_free, inb_free, outb_free, rng_free;
  logic [IDX_W-1:0]  prop_fidx, inb_fidx, outb_fidx, rng_fidx;
  logic              prop_wr, inb_wr, outb_wr, rng_wr;
  logic [IDX_W-1:0]  prop_widx, inb_widx, outb_widx, rng_widx;
  flw_key_t          prop_wkey, inb_wkey, outb_wkey, rng_wkey;
  logic [TGT_W-1:0]  prop_wdata, inb_wdata, outb_wdata;
  logic [RNG_W-1:0]  rng_wdata;
  logic [TGT_W-1:0]  prop_rd, inb_rd, outb_rd;
  logic [RNG_W-1:0]  rng_rd;

  flw_target_t prop_e;
  flw_range_t  rng_e;
  flw_target_t act_e;

  // Checksum unit operands.
  logic [15:0] cs_hc;
  logic [31:0] cs_old;
  logic [31:0] cs_new;
  logic [15:0] cs_res;

  logic accept;

  assign accept   = hdr.valid && hdr.ready;
  assign out_free = !res_valid || res.ready;
  assign prop_e   = flw_target_t'(prop_rd);
  assign rng_e    = flw_range_t'(rng_rd);

  // Activated inbound entry built from the proposal.
  always_comb begin
    act_e.addr = prop_e.addr;
    act_e.port = prop_e.port;
    act_e.a    = seq - prop_e.a;
    act_e.b    = ack - prop_e.b;
  end

  // Lookup keys.
  always_comb begin
    prop_lk = '{addr: sa, port: sp};
    inb_lk  = '{addr: sa, port: sp};
    rng_lk  = '{addr: sa, port: dp};
    if (state == ST_ACT) begin
      outb_lk = '{addr: tgt.addr, port: tgt.port};
    end else begin
      outb_lk = '{addr: da, port: dp};
    end
  end

  flw_table #(.ENTRIES(TABLE_ENTRIES), .DATA_W(TGT_W)) u_prop (
    .clk(clk), .rst(rst), .lookup(prop_lk), .hit(prop_hit), .hit_idx(prop_hidx),
    .has_free(prop_free), .free_idx(prop_fidx), .wr_en(prop_wr), .wr_idx(prop_widx),
    .wr_key(prop_wkey), .wr_data(prop_wdata), .rd_data(prop_rd)
  );

  flw_table #(.ENTRIES(TABLE_ENTRIES), .DATA_W(TGT_W)) u_inb (
    .clk(clk), .rst(rst), .lookup(inb_lk), .hit(inb_hit), .hit_idx(inb_hidx),
    .has_free(inb_free), .free_idx(inb_fidx), .wr_en(inb_wr), .wr_idx(inb_widx),
    .wr_key(inb_wkey), .wr_data(inb_wdata), .rd_data(inb_rd)
  );

  flw_table #(.ENTRIES(TABLE_ENTRIES), .DATA_W(TGT_W)) u_outb (
    .clk(clk), .rst(rst), .lookup(outb_lk), .hit(outb_hit), .hit_idx(outb_hidx),
    .has_free(outb_free), .free_idx(outb_fidx), .wr_en(outb_wr), .wr_idx(outb_widx),
    .wr_key(outb_wkey), .wr_data(outb_wdata), .rd_data(outb_rd)
  );

  flw_table #(.ENTRIES(TABLE_ENTRIES), .DATA_W(RNG_W)) u_rng (
    .clk(clk), .rst(rst), .lookup(rng_lk), .hit(rng_hit), .hit_idx(rng_hidx),
    .has_free(rng_free), .free_idx(rng_fidx), .wr_en(rng_wr), .wr_idx(rng_widx),
    .wr_key(rng_wkey), .wr_data(rng_wdata), .rd_data(rng_rd)
  );

  // Checksum operand selection per step.
  always_comb begin
    cs_hc  = (step == 3'd0) ? ipc : tcc;
    cs_old = (cmd == CMD_INBOUND) ? sa : da;
    cs_new = tgt.addr;
    unique case (step)
      3'd0, 3'd1: begin
        cs_old = (cmd == CMD_INBOUND) ? sa : da;
        cs_new = tgt.addr;
      end
      3'd2: begin
        cs_old = {16'hFFFF, (cmd == CMD_INBOUND) ? sp : dp};
        cs_new = {16'h0000, tgt.port};
      end
      3'd3: begin
        cs_old = (cmd == CMD_INBOUND) ? seq : ack;
        cs_new = (cmd == CMD_INBOUND) ? nseq : nack;
      end
      3'd4: begin
        cs_old = (cmd == CMD_INBOUND) ? ack : seq;
        cs_new = (cmd == CMD_INBOUND) ? nack : nseq;
      end
      default: begin
        cs_old = '0;
        cs_new = '0;
      end
    endcase
  end

  flw_csum u_csum (
    .hc(cs_hc), .old_val(cs_old), .new_val(cs_new), .result(cs_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_FIND;
      ST_FIND: begin
        if (cmd == CMD_LOAD_PROP || cmd == CMD_LOAD_RANGE) state_next = ST_DONE;
        else state_next = ST_READ;
      end
      ST_READ: begin
        if (cmd == CMD_INBOUND) begin
          if (inb_hit) state_next = ST_APPLY;
          else if (prop_hit) state_next = ST_ACT;
          else state_next = ST_RANGE;
        end else begin
          state_next = outb_hit ? ST_APPLY : ST_DONE;
        end
      end
      ST_ACT:   state_next = rew ? ST_APPLY : ST_RANGE;
      ST_APPLY: state_next = ST_CSUM;
      ST_CSUM: begin
        if (step == CSUM_LAST) begin
          state_next = (cmd == CMD_INBOUND) ? ST_RANGE : ST_DONE;
        end
      end
      ST_RANGE: state_next = ST_CLASS;
      ST_CLASS: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs: handshake and table writes.
  always_comb begin
    hdr.ready  = (state == ST_IDLE) && !rst;
    prop_wr    = 1'b0;
    prop_widx  = prop_hit ? prop_hidx : prop_fidx;
    prop_wkey  = '{addr: sa, port: sp};
    prop_wdata = TGT_W'({da, dp, seq, ack});
    rng_wr     = 1'b0;
    rng_widx   = rng_hit ? rng_hidx : rng_fidx;
    rng_wkey   = '{addr: sa, port: dp};
    rng_wdata  = RNG_W'({sp, stop});
    inb_wr     = 1'b0;
    inb_widx   = inb_fidx;
    inb_wkey   = '{addr: sa, port: sp};
    inb_wdata  = TGT_W'(act_e);
    outb_wr    = 1'b0;
    outb_widx  = outb_hit ? outb_hidx : outb_fidx;
    outb_wkey  = '{addr: tgt.addr, port: tgt.port};
    outb_wdata = TGT_W'({sa, sp, 32'(0 - tgt.b), 32'(0 - tgt.a)});
    unique case (state)
      ST_FIND: begin
        prop_wr = (cmd == CMD_LOAD_PROP) && (prop_hit || prop_free);
        rng_wr  = (cmd == CMD_LOAD_RANGE) && (rng_hit || rng_free);
      end
      ST_READ: begin
        inb_wr = (cmd == CMD_INBOUND) && !inb_hit && prop_hit && inb_free;
      end
      ST_ACT: begin
        outb_wr = outb_hit || outb_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd  <= hdr.item.command;
          sa   <= hdr.item.src_addr;
          sp   <= hdr.item.src_port;
          da   <= hdr.item.dst_addr;
          dp   <= hdr.item.dst_port;
          seq  <= hdr.item.seq_num;
          ack  <= hdr.item.ack_num;
          fin  <= hdr.item.fin_flag;
          rstf <= hdr.item.rst_flag;
          ipc  <= hdr.item.ip_checksum;
          tcc  <= hdr.item.tcp_checksum;
          stop <= hdr.item.range_stop;
          rew  <= 1'b0;
          full <= 1'b0;
          ev   <= EV_NONE;
        end
      end
      ST_FIND: begin
        if (cmd == CMD_LOAD_PROP) full <= !(prop_hit || prop_free);
        if (cmd == CMD_LOAD_RANGE) full <= !(rng_hit || rng_free);
      end
      ST_READ: begin
        if (cmd == CMD_INBOUND) begin
          if (inb_hit) begin
            tgt <= flw_target_t'(inb_rd);
            rew <= 1'b1;
          end else if (prop_hit) begin
            tgt  <= act_e;
            rew  <= inb_free;
            full <= !inb_free;
          end
        end else if (outb_hit) begin
          tgt <= flw_target_t'(outb_rd);
          rew <= 1'b1;
        end
      end
      ST_ACT: begin
        if (!(outb_hit || outb_free)) full <= 1'b1;
      end
      ST_APPLY: begin
        nseq <= seq - tgt.a;
        nack <= ack - tgt.b;
        step <= '0;
      end
      ST_CSUM: begin
        if (step == 3'd0) ipc <= cs_res;
        else tcc <= cs_res;
        step <= step + 3'd1;
        if (step == CSUM_LAST) begin
          seq <= nseq;
          ack <= nack;
          if (cmd == CMD_INBOUND) begin
            sa <= tgt.addr;
            sp <= tgt.port;
          end else begin
            da <= tgt.addr;
            dp <= tgt.port;
          end
        end
      end
      ST_CLASS: begin
        if (rng_hit && sp >= rng_e.start && sp <= rng_e.stop) begin
          if (ack == 32'd0) ev <= EV_CLEAR;
          else if (!fin && !rstf) ev <= EV_ADD;
          else ev <= EV_REMOVE;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result fields: loads report only the full flag.
  always_comb begin
    res_item_next = '0;
    res_item_next.table_full = full;
    if (cmd == CMD_INBOUND || cmd == CMD_OUTBOUND) begin
      res_item_next.out_src_addr     = sa;
      res_item_next.out_src_port     = sp;
      res_item_next.out_dst_addr     = da;
      res_item_next.out_dst_port     = dp;
      res_item_next.out_seq          = seq;
      res_item_next.out_ack          = ack;
      res_item_next.out_ip_checksum  = ipc;
      res_item_next.out_tcp_checksum = tcc;
      res_item_next.rewritten        = rew;
      res_item_next.pool_event       = ev;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      res_item <= res_item_next;
    end
  end

  assign res.valid = res_valid;
  assign res.item  = res_item;

`ifndef NO_ASSERTIONS
  // An accepted item always starts with the table lookup.
  a_accept_find: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_FIND)
    else $error("accepted item did not start lookup");

  // Loads never report a rewrite or a pool event.
  a_load_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (cmd == CMD_LOAD_PROP || cmd == CMD_LOAD_RANGE))
      |-> !rew && ev == EV_NONE)
    else $error("load carries header status");

  // Outbound headers never flag a full table or a pool event.
  a_outb_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && cmd == CMD_OUTBOUND) |-> !full && ev == EV_NONE)
    else $error("outbound result carries inbound status");

  // The checksum step counter stays within its five steps.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CSUM |-> step <= CSUM_LAST)
    else $error("checksum step out of range");

  // Checksum updates only run for a rewrite.
  a_csum_rew: assert property (@(posedge clk) disable iff (rst)
    state == ST_CSUM |-> rew)
    else $error("checksum update without rewrite");
`endif

endmodule

// File: verif/tcp_flow_rewrite_engine_tb.sv
// ----------------------------------------------------------------------------
// tcp_flow_rewrite_engine_tb: self-checking bench of the flow rewrite engine
// Drives header and table-load transactions with random idling on both
// channels, predicts each result with a behavioral copy of the flow tables,
// and compares every result transaction field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_flow_rewrite_engine_tb;
  import flw_pkg::*;

  localparam int ENTRIES = FLW_TABLE_ENTRIES;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic        valid;
    logic [31:0] addr;
    logic [15:0] port;
  } flow_key_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  flw_item_if   hdr ();
  flw_result_if res ();

  tcp_flow_rewrite_engine dut (
    .clk (clk),
    .rst (rst),
    .hdr (hdr.sink),
    .res (res.source)
  );

  always #5 clk = ~clk;

  // Predictor state: keys and payloads of the four tables.
  flow_key_t   prop_key [ENTRIES];
  flw_target_t prop_tgt [ENTRIES];
  flow_key_t   in_key   [ENTRIES];
  flw_target_t in_tgt   [ENTRIES];
  flow_key_t   out_key  [ENTRIES];
  flw_target_t out_tgt  [ENTRIES];
  flow_key_t   rng_key  [ENTRIES];
  flw_range_t  rng_bnd  [ENTRIES];

  flw_result_t expected_results [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          send_idle_pct;
  int          recv_idle_pct;

  // Small pools of keys so that lookups hit often.
  logic [31:0] addr_pool [8];
  logic [15:0] port_pool [8];

  function automatic int find_flow(ref flow_key_t t[ENTRIES], input logic [31:0] a,
                                   input logic [15:0] p);
    for (int k = 0; k < ENTRIES; k++)
      if (t[k].valid && t[k].addr == a && t[k].port == p) return k;
    return -1;
  endfunction

  function automatic int claim_flow(ref flow_key_t t[ENTRIES], input logic [31:0] a,
                                    input logic [15:0] p);
    int k;
    k = find_flow(t, a, p);
    if (k >= 0) return k;
    for (int m = 0; m < ENTRIES; m++)
      if (!t[m].valid) begin
        t[m].valid = 1'b1;
        t[m].addr = a;
        t[m].port = p;
        return m;
      end
    return -1;
  endfunction

  // Ones' complement fold of a sum, then inverted.
  function automatic logic [15:0] fold_inv(logic [31:0] s);
    s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return ~s[15:0];
  endfunction

  function automatic logic [15:0] csum_swap16(logic [15:0] hc, logic [15:0] o,
                                              logic [15:0] n);
    return fold_inv({16'd0, ~hc} + {16'd0, ~o} + {16'd0, n});
  endfunction

  function automatic logic [15:0] csum_swap32(logic [15:0] hc, logic [31:0] o,
                                              logic [31:0] n);
    logic [31:0] s;
    s = {16'd0, ~hc} + {16'd0, ~o[31:16]} + {16'd0, ~o[15:0]}
      + {16'd0, n[31:16]} + {16'd0, n[15:0]};
    return fold_inv(s);
  endfunction

  // Computes the rewrite result of one item and updates the tables.
  function automatic flw_result_t rewrite_header(flw_item_t it);
    flw_result_t r;
    flw_target_t e;
    int          i, j, p;
    logic [31:0] soff, aoff, nseq, nack;
    logic [15:0] ipc, tcc;
    r = '0;
    ipc = it.ip_checksum;
    tcc = it.tcp_checksum;
    case (it.command)
      CMD_LOAD_PROP: begin
        i = claim_flow(prop_key, it.src_addr, it.src_port);
        if (i < 0) r.table_full = 1'b1;
        else prop_tgt[i] = '{it.dst_addr, it.dst_port, it.seq_num, it.ack_num};
        return r;
      end
      CMD_LOAD_RANGE: begin
        i = claim_flow(rng_key, it.src_addr, it.dst_port);
        if (i < 0) r.table_full = 1'b1;
        else rng_bnd[i] = '{it.src_port, it.range_stop};
        return r;
      end
      CMD_INBOUND: begin
        i = find_flow(in_key, it.src_addr, it.src_port);
        if (i < 0) begin
          p = find_flow(prop_key, it.src_addr, it.src_port);
          if (p >= 0) begin
            soff = it.seq_num - prop_tgt[p].a;
            aoff = it.ack_num - prop_tgt[p].b;
            i = claim_flow(in_key, it.src_addr, it.src_port);
            if (i < 0) r.table_full = 1'b1;
            else in_tgt[i] = '{prop_tgt[p].addr, prop_tgt[p].port, soff, aoff};
            j = claim_flow(out_key, prop_tgt[p].addr, prop_tgt[p].port);
            if (j < 0) r.table_full = 1'b1;
            else out_tgt[j] = '{it.src_addr, it.src_port, 32'd0 - aoff, 32'd0 - soff};
          end
        end
        if (i >= 0) begin
          e = in_tgt[i];
          nseq = it.seq_num - e.a;
          nack = it.ack_num - e.b;
          ipc = csum_swap32(ipc, it.src_addr, e.addr);
          tcc = csum_swap32(tcc, it.src_addr, e.addr);
          tcc = csum_swap16(tcc, it.src_port, e.port);
          tcc = csum_swap32(tcc, it.seq_num, nseq);
          tcc = csum_swap32(tcc, it.ack_num, nack);
          it.src_addr = e.addr;
          it.src_port = e.port;
          it.seq_num = nseq;
          it.ack_num = nack;
          r.rewritten = 1'b1;
        end
        j = find_flow(rng_key, it.src_addr, it.dst_port);
        if (j >= 0 && it.src_port >= rng_bnd[j].start && it.src_port <= rng_bnd[j].stop)
        begin
          if (it.ack_num == 32'd0) r.pool_event = EV_CLEAR;
          else if (!it.fin_flag && !it.rst_flag) r.pool_event = EV_ADD;
          else r.pool_event = EV_REMOVE;
        end
      end
      default: begin
        i = find_flow(out_key, it.dst_addr, it.dst_port);
        if (i >= 0) begin
          e = out_tgt[i];
          nseq = it.seq_num - e.a;
          nack = it.ack_num - e.b;
          ipc = csum_swap32(ipc, it.dst_addr, e.addr);
          tcc = csum_swap32(tcc, it.dst_addr, e.addr);
          tcc = csum_swap16(tcc, it.dst_port, e.port);
          tcc = csum_swap32(tcc, it.ack_num, nack);
          tcc = csum_swap32(tcc, it.seq_num, nseq);
          it.dst_addr = e.addr;
          it.dst_port = e.port;
          it.seq_num = nseq;
          it.ack_num = nack;
          r.rewritten = 1'b1;
        end
      end
    endcase
    r.out_src_addr = it.src_addr;
    r.out_src_port = it.src_port;
    r.out_dst_addr = it.dst_addr;
    r.out_dst_port = it.dst_port;
    r.out_seq = it.seq_num;
    r.out_ack = it.ack_num;
    r.out_ip_checksum = ipc;
    r.out_tcp_checksum = tcc;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sends one transaction, with random idle cycles in front of it. Valid stays
  // high between transactions that follow back to back.
  task automatic send_item(flw_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      hdr.valid <= 1'b0;
      @(posedge clk);
    end
    hdr.valid <= 1'b1;
    hdr.item <= it;
    do @(posedge clk); while (!hdr.ready);
    expected_results.push_back(rewrite_header(it));
  endtask

  // Receiver: random stalls, and an in-order check of each transaction.
  always @(posedge clk) begin
    flw_result_t got, want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got = res.item;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transaction", 32'd1, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.out_src_addr !== want.out_src_addr)
            report_mismatch("out_src_addr", got.out_src_addr, want.out_src_addr);
          if (got.out_src_port !== want.out_src_port)
            report_mismatch("out_src_port", got.out_src_port, want.out_src_port);
          if (got.out_dst_addr !== want.out_dst_addr)
            report_mismatch("out_dst_addr", got.out_dst_addr, want.out_dst_addr);
          if (got.out_dst_port !== want.out_dst_port)
            report_mismatch("out_dst_port", got.out_dst_port, want.out_dst_port);
          if (got.out_seq !== want.out_seq)
            report_mismatch("out_seq", got.out_seq, want.out_seq);
          if (got.out_ack !== want.out_ack)
            report_mismatch("out_ack", got.out_ack, want.out_ack);
          if (got.out_ip_checksum !== want.out_ip_checksum)
            report_mismatch("out_ip_checksum", got.out_ip_checksum, want.out_ip_checksum);
          if (got.out_tcp_checksum !== want.out_tcp_checksum)
            report_mismatch("out_tcp_checksum", got.out_tcp_checksum,
                            want.out_tcp_checksum);
          if (got.rewritten !== want.rewritten)
            report_mismatch("rewritten", got.rewritten, want.rewritten);
          if (got.pool_event !== want.pool_event)
            report_mismatch("pool_event", got.pool_event, want.pool_event);
          if (got.table_full !== want.table_full)
            report_mismatch("table_full", got.table_full, want.table_full);
        end
      end
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((hdr.valid && hdr.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** tcp_flow_rewrite_engine: FAILED **");
      $finish;
    end
  end

  function automatic flw_item_t random_item(flw_cmd_t cmd);
    flw_item_t it;
    it = '{cmd, $urandom, 16'($urandom), $urandom, 16'($urandom), $urandom, $urandom,
           1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    return it;
  endfunction

  // Item drawn from the key pools, with random content.
  function automatic flw_item_t pooled_item(flw_cmd_t cmd);
    flw_item_t it;
    it = random_item(cmd);
    it.src_addr = addr_pool[$urandom_range(7)];
    it.src_port = port_pool[$urandom_range(7)];
    it.dst_addr = addr_pool[$urandom_range(7)];
    it.dst_port = port_pool[$urandom_range(7)];
    if ($urandom_range(9) == 0) it.ack_num = 32'd0;
    if (cmd == CMD_LOAD_RANGE && $urandom_range(3) != 0) begin
      it.src_port = 16'($urandom_range(32767));
      it.range_stop = 16'($urandom_range(65535, 32768));
    end
    return it;
  endfunction

  task automatic test_extremes();
    flw_item_t it;
    for (int c = 0; c < 4; c++) begin
      it = '1;
      it.command = flw_cmd_t'(c);
      send_item(it);
      it = '0;
      it.command = flw_cmd_t'(c);
      send_item(it);
    end
  endtask

  // Activation, rewrite in both directions, classification, inverted range.
  task automatic test_flow_activation();
    flw_item_t it;
    it = random_item(CMD_LOAD_PROP);
    it.src_addr = 32'h0a00_0001; it.src_port = 16'd1000;
    it.dst_addr = 32'hc0a8_0001; it.dst_port = 16'd80;
    send_item(it);
    it = random_item(CMD_LOAD_RANGE);
    it.src_addr = 32'hc0a8_0001; it.dst_port = 16'd443;
    it.src_port = 16'd0; it.range_stop = 16'd100;
    send_item(it);
    it.src_addr = 32'h0a00_0001; it.dst_port = 16'd22;
    it.src_port = 16'd5000; it.range_stop = 16'd10;
    send_item(it);
    for (int k = 0; k < 4; k++) begin
      it = random_item(CMD_INBOUND);
      it.src_addr = 32'h0a00_0001; it.src_port = 16'd1000; it.dst_port = 16'd443;
      it.fin_flag = k[0]; it.rst_flag = k[1];
      if (k == 3) it.ack_num = 32'd0;
      send_item(it);
    end
    it = random_item(CMD_OUTBOUND);
    it.dst_addr = 32'hc0a8_0001; it.dst_port = 16'd80;
    send_item(it);
    it = random_item(CMD_INBOUND);
    it.src_addr = 32'h0a00_0001; it.src_port = 16'd5000; it.dst_port = 16'd22;
    send_item(it);
  endtask

  // Fills the tables past their size so that full flags show.
  task automatic test_table_full();
    flw_item_t it;
    for (int k = 0; k < ENTRIES + 2; k++) begin
      it = random_item(CMD_LOAD_PROP);
      it.src_addr = 32'h0b00_0000 + k; it.src_port = 16'd7;
      send_item(it);
      it = random_item(CMD_INBOUND);
      it.src_addr = 32'h0b00_0000 + k; it.src_port = 16'd7;
      send_item(it);
      it.command = CMD_LOAD_RANGE;
      send_item(it);
    end
  endtask

  task automatic test_random(int count);
    flw_cmd_t  cmd;
    int        pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 10) cmd = CMD_LOAD_PROP;
      else if (pick < 15) cmd = CMD_LOAD_RANGE;
      else if (pick < 65) cmd = CMD_INBOUND;
      else cmd = CMD_OUTBOUND;
      if ($urandom_range(9) == 0) send_item(random_item(cmd));
      else send_item(pooled_item(cmd));
    end
  endtask

  initial begin
    hdr.valid = 1'b0;
    hdr.item = '0;
    foreach (prop_key[k]) begin
      prop_key[k].valid = 1'b0;
      in_key[k].valid = 1'b0;
      out_key[k].valid = 1'b0;
      rng_key[k].valid = 1'b0;
    end
    foreach (addr_pool[k]) begin
      addr_pool[k] = $urandom;
      port_pool[k] = 16'($urandom);
    end
    send_idle_pct = 10;
    recv_idle_pct = 71;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_flow_activation();
    test_random(500);
    send_idle_pct = 71;
    recv_idle_pct = 10;
    test_table_full();
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(500);
    hdr.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** tcp_flow_rewrite_engine: PASSED **");
    end else begin
      $display("** tcp_flow_rewrite_engine: FAILED **");
    end
    $finish;
  end

endmodule
